@@ hw/rtl/twpl_pkg.sv @@
// Shared constants and types for the 26-letter trie lookup block.
// No dependencies; imported by trie_word_and_prefix_lookup_top.
package twpl_pkg;

   localparam int NODE_COUNT    = 1024;
   localparam int ALPHABET_SIZE = 26;
   localparam int NODE_BITS     = $clog2(NODE_COUNT);
   localparam int LETTER_BITS   = 5;
   localparam int OP_BITS       = 2;
   localparam int SLOT_BITS     = NODE_BITS + LETTER_BITS;

   typedef logic [NODE_BITS-1:0]     node_idx_type;
   typedef logic [NODE_BITS:0]       node_cnt_type;
   typedef logic [LETTER_BITS-1:0]   letter_type;
   typedef logic [OP_BITS-1:0]       op_type;
   typedef logic [ALPHABET_SIZE-1:0] child_mask_type;
   typedef logic [SLOT_BITS-1:0]     slot_idx_type;

   localparam op_type OP_INSERT = 2'd0;
   localparam op_type OP_SEARCH = 2'd1;
   localparam op_type OP_PREFIX = 2'd2;
   localparam op_type OP_CLEAR  = 2'd3;

endpackage

@@ hw/rtl/trie_word_and_prefix_lookup_top.sv @@
// Prefix trie over a fixed node pool: child pointer, child mask and word-end memories.
// Depends on twpl_pkg.
//
// Usage:
//   Drive one letter per transfer on req_op/req_has_letter/req_letter/req_last
//   and raise start; the transfer happens at a clock edge with start high and
//   busy low. Keep req_op the same across a word. The item with req_last = 1
//   yields one result: rsp_strobe is high for exactly one cycle with
//   rsp_found and rsp_overflow, and that cycle is the transfer; the receiver
//   cannot stall it.
// Steps per item:
//   letter whose link exists          : node read, cursor update
//   letter that allocates a node      : read, link write, node clear
//   last item                         : an extra end state for the word-end mark
//   clear, or non-last item without a letter or after a miss: handled in idle
//   Registered node memory reads set these steps; the result strobe
//   is registered and rises in the cycle after the final state.
// Reset (synchronous, active high) returns the walk to the root, frees the
// pool and writes an empty root entry; the block accepts items right after.
module trie_word_and_prefix_lookup_top (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  twpl_pkg::op_type      req_op,
   input  logic                  req_has_letter,
   input  twpl_pkg::letter_type  req_letter,
   input  logic                  req_last,
   output logic                  rsp_strobe,
   output logic                  rsp_found,
   output logic                  rsp_overflow
);
   import twpl_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_LOOK  = 2'd1;
   localparam logic [1:0] ST_ALLOC = 2'd2;
   localparam logic [1:0] ST_END   = 2'd3;

   localparam int SLOT_COUNT = NODE_COUNT * (2 ** LETTER_BITS);

   // node memories
   node_idx_type   ptr_mem  [SLOT_COUNT];
   child_mask_type mask_mem [NODE_COUNT];
   logic           mark_mem [NODE_COUNT];

   // control registers
   logic [1:0]   state_ff, state_in;
   node_idx_type cursor_ff, cursor_in;
   logic         miss_ff, miss_in;
   logic         exhausted_ff, exhausted_in;
   node_cnt_type next_free_ff, next_free_in;
   logic         rsp_strobe_ff, rsp_strobe_in;
   logic         rsp_found_ff, rsp_found_in;
   logic         rsp_overflow_ff, rsp_overflow_in;

   // item registers
   op_type     op_ff, op_in;
   letter_type letter_ff, letter_in;
   logic       last_ff, last_in;

   // memory read data
   node_idx_type   ptr_q;
   child_mask_type mask_q;
   logic           mark_q;

   // memory ports
   letter_type     ptr_rletter;
   logic           ptr_we;
   slot_idx_type   ptr_waddr;
   node_idx_type   ptr_wdata;
   logic           mask_we;
   node_idx_type   mask_waddr;
   child_mask_type mask_wdata;
   logic           mark_we;
   node_idx_type   mark_waddr;
   logic           mark_wdata;

   logic accept;
   logic walk;
   logic link_valid;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;
   assign walk   = req_has_letter && !miss_ff &&
                   (req_letter < LETTER_BITS'(ALPHABET_SIZE));
   assign link_valid = mask_q[letter_ff];

   assign ptr_rletter = busy ? letter_ff : req_letter;

   always_comb begin
      state_in        = state_ff;
      cursor_in       = cursor_ff;
      miss_in         = miss_ff;
      exhausted_in    = exhausted_ff;
      next_free_in    = next_free_ff;
      op_in           = op_ff;
      letter_in       = letter_ff;
      last_in         = last_ff;
      rsp_strobe_in   = 1'b0;
      rsp_found_in    = 1'b0;
      rsp_overflow_in = 1'b0;
      ptr_we          = 1'b0;
      ptr_waddr       = {cursor_ff, letter_ff};
      ptr_wdata       = next_free_ff[NODE_BITS-1:0];
      mask_we         = 1'b0;
      mask_waddr      = cursor_ff;
      mask_wdata      = '0;
      mark_we         = 1'b0;
      mark_waddr      = cursor_ff;
      mark_wdata      = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in     = req_op;
               letter_in = req_letter;
               last_in   = req_last;
               if (req_op == OP_CLEAR) begin
                  // empty the root and free the pool
                  mask_we       = 1'b1;
                  mask_waddr    = '0;
                  mark_we       = 1'b1;
                  mark_waddr    = '0;
                  next_free_in  = (NODE_BITS+1)'(1);
                  cursor_in     = '0;
                  miss_in       = 1'b0;
                  exhausted_in  = 1'b0;
                  rsp_strobe_in = req_last;
               end else if (walk) begin
                  state_in = ST_LOOK;
               end else begin
                  if (req_has_letter && !miss_ff) begin
                     miss_in = 1'b1;
                  end
                  if (req_last) begin
                     state_in = ST_END;
                  end
               end
            end
         end
         ST_LOOK: begin
            state_in = last_ff ? ST_END : ST_IDLE;
            if (link_valid) begin
               cursor_in = ptr_q;
            end else if (op_ff != OP_INSERT) begin
               miss_in = 1'b1;
            end else if (next_free_ff == (NODE_BITS+1)'(NODE_COUNT)) begin
               exhausted_in = 1'b1;
               miss_in      = 1'b1;
            end else begin
               // link a fresh node; its mask is cleared in the next cycle
               ptr_we       = 1'b1;
               mask_we      = 1'b1;
               mask_wdata   = mask_q | (child_mask_type'(1) << letter_ff);
               mark_we      = 1'b1;
               mark_waddr   = next_free_ff[NODE_BITS-1:0];
               cursor_in    = next_free_ff[NODE_BITS-1:0];
               next_free_in = next_free_ff + (NODE_BITS+1)'(1);
               state_in     = ST_ALLOC;
            end
         end
         ST_ALLOC: begin
            mask_we  = 1'b1;
            state_in = last_ff ? ST_END : ST_IDLE;
         end
         ST_END: begin
            rsp_strobe_in = 1'b1;
            case (op_ff)
               OP_INSERT: begin
                  mark_we         = !miss_ff;
                  mark_wdata      = 1'b1;
                  rsp_overflow_in = exhausted_ff;
               end
               OP_SEARCH: rsp_found_in = !miss_ff && mark_q;
               OP_PREFIX: rsp_found_in = !miss_ff;
               default:   rsp_found_in = 1'b0;
            endcase
            cursor_in    = '0;
            miss_in      = 1'b0;
            exhausted_in = 1'b0;
            state_in     = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase

      // reset writes an empty root entry
      if (reset) begin
         mask_we    = 1'b1;
         mask_waddr = '0;
         mask_wdata = '0;
         mark_we    = 1'b1;
         mark_waddr = '0;
         mark_wdata = 1'b0;
         ptr_we     = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         cursor_ff       <= '0;
         miss_ff         <= 1'b0;
         exhausted_ff    <= 1'b0;
         next_free_ff    <= (NODE_BITS+1)'(1);
         rsp_strobe_ff   <= 1'b0;
      end else begin
         state_ff        <= state_in;
         cursor_ff       <= cursor_in;
         miss_ff         <= miss_in;
         exhausted_ff    <= exhausted_in;
         next_free_ff    <= next_free_in;
         rsp_strobe_ff   <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff           <= op_in;
      letter_ff       <= letter_in;
      last_ff         <= last_in;
      rsp_found_ff    <= rsp_found_in;
      rsp_overflow_ff <= rsp_overflow_in;
   end

   always_ff @(posedge clock) begin
      if (ptr_we) begin
         ptr_mem[ptr_waddr] <= ptr_wdata;
      end
      ptr_q <= ptr_mem[{cursor_ff, ptr_rletter}];
   end

   always_ff @(posedge clock) begin
      if (mask_we) begin
         mask_mem[mask_waddr] <= mask_wdata;
      end
      mask_q <= mask_mem[cursor_ff];
   end

   // read at the next cursor so the end state sees the mark of the final node
   always_ff @(posedge clock) begin
      if (mark_we) begin
         mark_mem[mark_waddr] <= mark_wdata;
      end
      mark_q <= mark_mem[cursor_in];
   end

   assign rsp_strobe   = rsp_strobe_ff;
   assign rsp_found    = rsp_found_ff;
   assign rsp_overflow = rsp_overflow_ff;

`ifndef SYNTHESIS
   a_cursor_allocated: assert property (@(posedge clock) disable iff (reset)
      (NODE_BITS+1)'(cursor_ff) < next_free_ff)
      else $error("cursor points at an unallocated node");

   a_pool_bound: assert property (@(posedge clock) disable iff (reset)
      next_free_ff != '0 && next_free_ff <= (NODE_BITS+1)'(NODE_COUNT))
      else $error("free-node counter out of range");

   a_end_gives_result: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_END |=> rsp_strobe)
      else $error("end of word without a result");

   a_overflow_not_found: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !(rsp_found && rsp_overflow))
      else $error("result reports both found and overflow");
`endif

endmodule

@@ tb/trie_lookup_checker.sv @@
`timescale 1ns / 100ps
// Checker for the trie lookup block: tracks its own trie and compares results.
// Depends on twpl_pkg; instantiated by tb beside the block.
module trie_lookup_checker (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  busy,
   input  twpl_pkg::op_type      req_op,
   input  logic                  req_has_letter,
   input  twpl_pkg::letter_type  req_letter,
   input  logic                  req_last,
   input  logic                  rsp_strobe,
   input  logic                  rsp_found,
   input  logic                  rsp_overflow,
   output int                    mismatches,
   output int                    pending
);
   import twpl_pkg::*;

   localparam int FIFO_DEPTH = 16;

   typedef struct packed {
      logic found;
      logic overflow;
   } lookup_answer_type;

   lookup_answer_type answer_fifo [FIFO_DEPTH];
   int                wr_count = 0;
   int                rd_count = 0;

   node_idx_type   cursor;
   logic           walk_missed;
   logic           pool_full;
   node_cnt_type   next_free;
   node_idx_type   child_ptr [NODE_COUNT*ALPHABET_SIZE];
   child_mask_type child_ok [NODE_COUNT];
   logic           word_end [NODE_COUNT];

   int                error_count = 0;
   int                result_count = 0;
   lookup_answer_type want;

   assign mismatches = error_count;

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   task automatic restart_walk();
      cursor      = '0;
      walk_missed = 1'b0;
      pool_full   = 1'b0;
   endtask

   task automatic empty_trie();
      child_ok[0] = '0;
      word_end[0] = 1'b0;
      next_free   = node_cnt_type'(1);
      restart_walk();
   endtask

   // Advance the walk by one accepted transfer; queue the answer on the last one.
   task automatic walk_trie(input op_type op, input logic has_letter,
                            input letter_type ltr, input logic last);
      int                slot;
      lookup_answer_type ans;
      if (op == OP_CLEAR) begin
         empty_trie();
      end else if (has_letter && !walk_missed) begin
         if (ltr >= ALPHABET_SIZE) begin
            walk_missed = 1'b1;
         end else begin
            slot = int'(cursor) * ALPHABET_SIZE + int'(ltr);
            if (child_ok[cursor][ltr]) begin
               cursor = child_ptr[slot];
            end else if (op != OP_INSERT) begin
               walk_missed = 1'b1;
            end else if (next_free >= NODE_COUNT) begin
               pool_full   = 1'b1;
               walk_missed = 1'b1;
            end else begin
               child_ok[next_free[NODE_BITS-1:0]] = '0;
               word_end[next_free[NODE_BITS-1:0]] = 1'b0;
               child_ptr[slot]        = next_free[NODE_BITS-1:0];
               child_ok[cursor][ltr]  = 1'b1;
               next_free              = next_free + 1'b1;
               cursor                 = child_ptr[slot];
            end
         end
      end
      if (last) begin
         ans = '0;
         case (op)
            OP_INSERT: begin
               if (!walk_missed) word_end[cursor] = 1'b1;
               ans.overflow = pool_full;
            end
            OP_SEARCH: ans.found = !walk_missed && word_end[cursor];
            OP_PREFIX: ans.found = !walk_missed;
            default: ;
         endcase
         answer_fifo[wr_count % FIFO_DEPTH] = ans;
         wr_count++;
         restart_walk();
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         wr_count = 0;
         rd_count = 0;
         empty_trie();
      end else begin
         // Check the result before taking in a new transfer at the same edge.
         if (rsp_strobe === 1'b1) begin
            result_count++;
            if (wr_count == rd_count) begin
               report_mismatch($sformatf("result %0d with nothing expected", result_count));
            end else begin
               want = answer_fifo[rd_count % FIFO_DEPTH];
               rd_count++;
               if (rsp_found !== want.found)
                  report_mismatch($sformatf("result %0d: found %b, want %b",
                                            result_count, rsp_found, want.found));
               if (rsp_overflow !== want.overflow)
                  report_mismatch($sformatf("result %0d: overflow %b, want %b",
                                            result_count, rsp_overflow, want.overflow));
            end
         end
         if (start && !busy)
            walk_trie(req_op, req_has_letter, req_letter, req_last);
      end
      pending <= wr_count - rd_count;
   end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// Top of the trie lookup testbench: clock, reset, word stimulus and verdict.
// Depends on twpl_pkg, trie_word_and_prefix_lookup_top and trie_lookup_checker.
module tb;
   import twpl_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int MAX_LEN     = 24;
   localparam int BANK_WORDS  = 64;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   op_type      req_op = OP_INSERT;
   logic        req_has_letter = 1'b0;
   letter_type  req_letter = '0;
   logic        req_last = 1'b0;
   logic        busy;
   logic        rsp_strobe;
   logic        rsp_found;
   logic        rsp_overflow;
   int          mismatches;
   int          pending;

   int          cycle_count = 0;
   int          items_sent = 0;
   logic        idle_mode = 1'b1;
   letter_type  cur_word [MAX_LEN];
   letter_type  bank [BANK_WORDS][MAX_LEN];
   int          bank_len [BANK_WORDS];
   int          bank_fill = 0;
   int          bank_next = 0;
   int          drain;

   trie_word_and_prefix_lookup_top u_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_op         (req_op),
      .req_has_letter (req_has_letter),
      .req_letter     (req_letter),
      .req_last       (req_last),
      .rsp_strobe     (rsp_strobe),
      .rsp_found      (rsp_found),
      .rsp_overflow   (rsp_overflow)
   );

   trie_lookup_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_op         (req_op),
      .req_has_letter (req_has_letter),
      .req_letter     (req_letter),
      .req_last       (req_last),
      .rsp_strobe     (rsp_strobe),
      .rsp_found      (rsp_found),
      .rsp_overflow   (rsp_overflow),
      .mismatches     (mismatches),
      .pending        (pending)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   function automatic int pick_gap();
      int r;
      if (!idle_mode) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Drive one transfer, hold until accepted, then idle for a random gap or none.
   task automatic send_letter(input op_type op, input logic has_letter,
                              input letter_type ltr, input logic last);
      int gap;
      req_op         <= op;
      req_has_letter <= has_letter;
      req_letter     <= ltr;
      req_last       <= last;
      start          <= 1'b1;
      do @(posedge clock); while (busy);
      items_sent++;
      if (items_sent % 150 == 0) idle_mode = ($urandom_range(0, 3) != 0);
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_text(input op_type op, input int len);
      if (len == 0) begin
         send_letter(op, 1'b0, letter_type'($urandom_range(0, 31)), 1'b1);
      end else begin
         for (int i = 0; i < len; i++)
            send_letter(op, 1'b1, cur_word[i], i == len - 1);
      end
   endtask

   task automatic make_word(input int len, input int top_letter);
      for (int i = 0; i < len; i++)
         cur_word[i] = letter_type'($urandom_range(0, top_letter));
   endtask

   task automatic save_word(input int len);
      for (int i = 0; i < len; i++) bank[bank_next][i] = cur_word[i];
      bank_len[bank_next] = len;
      bank_next = (bank_next + 1) % BANK_WORDS;
      if (bank_fill < BANK_WORDS) bank_fill++;
   endtask

   // Load a stored word into cur_word, or a fresh one when the bank is empty.
   task automatic load_word(output int len);
      int idx;
      if (bank_fill == 0) begin
         len = $urandom_range(1, 6);
         make_word(len, 25);
      end else begin
         idx = $urandom_range(0, bank_fill - 1);
         len = bank_len[idx];
         for (int i = 0; i < len; i++) cur_word[i] = bank[idx][i];
      end
   endtask

   task automatic run_mixed(input int target);
      int     r;
      int     len;
      op_type op;
      while (items_sent < target) begin
         r = $urandom_range(0, 99);
         if (r < 3) begin
            send_letter(OP_CLEAR, 1'($urandom_range(0, 1)),
                        letter_type'($urandom_range(0, 31)), 1'b1);
         end else if (r < 10) begin
            // Broken word: op, letter presence and letter vary per transfer.
            len = $urandom_range(1, 5);
            for (int i = 0; i < len; i++)
               send_letter(op_type'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                           letter_type'($urandom_range(0, 31)), i == len - 1);
         end else begin
            r  = $urandom_range(0, 99);
            op = (r < 40) ? OP_INSERT : (r < 70) ? OP_SEARCH : OP_PREFIX;
            if (op != OP_INSERT && $urandom_range(0, 1)) begin
               load_word(len);
               if (op == OP_PREFIX && len > 0) len = $urandom_range(1, len);
            end else begin
               len = $urandom_range(0, 6);
               make_word(len, 3);
               if (len > 0 && $urandom_range(0, 99) < 4)
                  cur_word[$urandom_range(0, len - 1)] = letter_type'($urandom_range(26, 31));
               if (op == OP_INSERT) save_word(len);
            end
            send_text(op, len);
         end
      end
   endtask

   // Insert-heavy traffic over the whole alphabet to grow a deep, wide trie.
   task automatic run_fill(input int target);
      int r;
      int len;
      while (items_sent < target) begin
         r = $urandom_range(0, 99);
         if (r < 90) begin
            len = $urandom_range(6, 20);
            make_word(len, 25);
            save_word(len);
            send_text(OP_INSERT, len);
         end else begin
            load_word(len);
            if (r < 95) begin
               send_text(OP_SEARCH, len);
            end else begin
               if (len > 0) len = $urandom_range(1, len);
               send_text(OP_PREFIX, len);
            end
         end
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Empty words act on the root.
      send_text(OP_SEARCH, 0);
      send_text(OP_PREFIX, 0);
      send_text(OP_INSERT, 0);
      send_text(OP_SEARCH, 0);
      // Lowest and highest letters.
      cur_word[0] = letter_type'(0);
      cur_word[1] = letter_type'(25);
      cur_word[2] = letter_type'(0);
      send_text(OP_INSERT, 3);
      send_text(OP_SEARCH, 3);
      send_text(OP_SEARCH, 2);
      // Out-of-range letter stops the insert after one allocation.
      cur_word[0] = letter_type'(25);
      cur_word[1] = letter_type'(31);
      send_text(OP_INSERT, 2);
      send_text(OP_SEARCH, 1);
      send_text(OP_PREFIX, 1);
      cur_word[0] = letter_type'(26);
      send_text(OP_SEARCH, 1);
      // Mixed ops in one word, then a clear in the middle of a word.
      send_letter(OP_INSERT, 1'b1, letter_type'(5), 1'b0);
      send_letter(OP_SEARCH, 1'b1, letter_type'(6), 1'b1);
      send_letter(OP_INSERT, 1'b1, letter_type'(7), 1'b0);
      send_letter(OP_CLEAR, 1'b0, letter_type'(0), 1'b0);
      send_letter(OP_PREFIX, 1'b1, letter_type'(7), 1'b1);
      send_letter(OP_CLEAR, 1'b1, letter_type'(31), 1'b1);
      // A letterless transfer inside a word takes no step.
      send_letter(OP_INSERT, 1'b0, letter_type'(3), 1'b0);
      send_letter(OP_INSERT, 1'b1, letter_type'(3), 1'b1);

      run_mixed(items_sent + 400);
      send_letter(OP_CLEAR, 1'b0, letter_type'(0), 1'b1);
      run_fill(items_sent + 600);
      send_letter(OP_CLEAR, 1'b0, letter_type'(0), 1'b1);
      run_mixed(items_sent + 60);
      start <= 1'b0;

      drain = 0;
      while (pending != 0 && drain < 2000) begin
         @(posedge clock);
         drain++;
      end
      repeat (16) @(posedge clock);
      if (pending != 0) $display("%0d results never arrived", pending);
      if (mismatches == 0 && pending == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
